FILE: rtl/ovs_pkg.sv
// Shared types, constants and helpers for the one-vs-one linear SVM classifier.
// No dependencies; used by every module of the block.
package ovs_pkg;

	// Default sizing, handed to the top-level parameters
	localparam int DEF_MAX_FEATURES = 64;
	localparam int DEF_MAX_CLASSES  = 8;
	localparam int DEF_MAX_PAIRS    = 28;

	// Field and datapath widths
	localparam int FEATURE_COUNT_W = 7;
	localparam int CLASS_COUNT_W   = 4;
	localparam int ACTION_W        = 2;
	localparam int ADDR_W          = 11;
	localparam int VALUE_W         = 32;
	localparam int COEF_W          = 16;
	localparam int BIAS_W          = 32;
	localparam int PROD_W          = 32;
	localparam int ACC_W           = 48;
	localparam int VOTE_W          = 3;
	localparam int CLASS_OUT_W     = 3;

	// Port widths
	localparam int S_TDATA_W  = 48;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	// Register reset values
	localparam logic [FEATURE_COUNT_W-1:0] FEATURE_COUNT_RST = 7'd64;
	localparam logic [CLASS_COUNT_W-1:0]   CLASS_COUNT_RST   = 4'd8;

	// Request kinds carried on s_tuser
	localparam logic [ACTION_W-1:0] ACT_WEIGHT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BIAS   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT   = 4'd1;

	// Sequencer to MAC datapath
	typedef struct packed {
		logic wr_weight;
		logic wr_bias;
		logic wr_sample;
		logic issue;
		logic clear_acc;
	} mac_ctrl_t;

	// MAC datapath back to sequencer
	typedef struct packed {
		logic busy;
		logic positive;
	} mac_stat_t;

	// Sequencer to vote tally
	typedef struct packed {
		logic clear;
		logic vote;
		logic scan;
	} tally_ctrl_t;

	// Clamp a signed word to the signed 16-bit range
	function automatic logic signed [COEF_W-1:0] sat16(input logic signed [VALUE_W-1:0] v);
		if (v > 32'sd32767) begin
			return 16'sh7fff;
		end else if (v < -32'sd32768) begin
			return 16'sh8000;
		end
		return v[COEF_W-1:0];
	endfunction

endpackage

FILE: rtl/ovo_linear_svm_classifier.sv
// One-vs-one linear SVM classifier: handshakes, configuration and sequencer.
// Depends on ovs_pkg, ovs_mac and ovs_tally.
//
// Usage:
//   Requests arrive on s_* with the kind on s_tuser: coefficient write, intercept
//   write, or the next feature sample. The feature sample that completes a vector
//   starts a classification run, and one class index leaves on m_* when it ends.
//   For each pair the sequencer issues F feature products, F the feature count,
//   waits for the read and multiply stages to drain, then adds the intercept and
//   votes. It then scans the C classes, C the class count, and loads the output.
//   The single multiply-accumulate unit serves every pair; s_tready is low during
//   the run.
//   A finished result waits in the output register; s_tready returns high as soon
//   as it is loaded, so new requests are taken while the receiver stalls. A run
//   that ends while the previous result is still held waits for m_tready.
//   Configuration writes (cfg_*) are always accepted and must be issued while the
//   block is idle. Index 0 is feature_count, index 1 is class_count.
//   Reset clears the sample count, votes and handshakes and sets the registers to
//   64 features and 8 classes; memory contents are undefined until written.
module ovo_linear_svm_classifier
	import ovs_pkg::*;
#(
	parameter int MAX_FEATURES = DEF_MAX_FEATURES,
	parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
	parameter int MAX_PAIRS    = DEF_MAX_PAIRS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // address[10:0], value[42:11], zero pad
	input  logic [S_TUSER_W-1:0]  s_tuser,   // action[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // class_index[2:0], zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WDEPTH = MAX_PAIRS * MAX_FEATURES;
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int FCW    = $clog2(MAX_FEATURES + 1);
	localparam int CW     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int CCW    = $clog2(MAX_CLASSES + 1);
	localparam int NPAIRS = MAX_CLASSES * (MAX_CLASSES - 1) / 2;
	localparam int PCW    = $clog2(NPAIRS + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MAC   = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_SUM   = 6'b001000,
		ST_SCAN  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t                     state_q;
	logic [FEATURE_COUNT_W-1:0] fc_q;
	logic [CLASS_COUNT_W-1:0]   cc_q;
	logic [FCW-1:0]             rcv_q;
	logic [FW-1:0]              feat_q;
	logic [CW-1:0]              i_q;
	logic [CW-1:0]              j_q;
	logic [PCW-1:0]             pair_q;
	logic [WAW-1:0]             base_q;
	logic                       m_tvalid_q;
	logic [CLASS_OUT_W-1:0]     class_q;

	logic [ACTION_W-1:0]        action;
	logic [ADDR_W-1:0]          address;
	logic signed [VALUE_W-1:0]  value;
	logic                       s_fire;
	logic                       sample_in;
	logic [FCW-1:0]             rcv_inc;
	logic                       start;
	logic [FCW-1:0]             nf;
	logic [CCW-1:0]             nc;
	logic                       last_feat;
	logic                       j_more;
	logic                       pairs_done;
	logic [PCW-1:0]             next_pair;
	logic                       run_out;
	logic                       scan_last;
	logic                       out_free;
	logic [FW-1:0]              sample_idx;
	logic [WAW-1:0]             coef_addr;
	logic [CW-1:0]              vote_idx;
	logic [CW-1:0]              best;
	mac_ctrl_t                  mac_ctrl;
	mac_stat_t                  mac_stat;
	tally_ctrl_t                tally_ctrl;

	// Request fields
	assign action  = s_tuser[ACTION_W-1:0];
	assign address = s_tdata[ADDR_W-1:0];
	assign value   = s_tdata[ADDR_W+VALUE_W-1:ADDR_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = M_TDATA_W'(class_q);
	assign out_free  = !m_tvalid_q || m_tready;

	// Effective counts, clamped to the supported range
	always_comb begin
		if (fc_q == '0) begin
			nf = FCW'(1);
		end else if (32'(fc_q) > MAX_FEATURES) begin
			nf = FCW'(MAX_FEATURES);
		end else begin
			nf = FCW'(fc_q);
		end
		if (32'(cc_q) < 2) begin
			nc = CCW'(2);
		end else if (32'(cc_q) > MAX_CLASSES) begin
			nc = CCW'(MAX_CLASSES);
		end else begin
			nc = CCW'(cc_q);
		end
	end

	// Loop conditions
	assign sample_in  = s_fire && (action == ACT_SAMPLE);
	assign rcv_inc    = rcv_q + 1'b1;
	assign start      = sample_in && (rcv_inc >= nf);
	assign last_feat  = (FCW'(feat_q) + FCW'(1)) == nf;
	assign j_more     = (32'(j_q) + 1) < 32'(nc);
	assign pairs_done = !j_more && !((32'(i_q) + 2) < 32'(nc));
	assign next_pair  = pair_q + 1'b1;
	assign run_out    = 32'(next_pair) >= MAX_PAIRS;
	assign scan_last  = (32'(i_q) + 1) >= 32'(nc);

	// Datapath addressing
	assign sample_idx = (state_q == ST_IDLE) ? FW'(rcv_q) : feat_q;
	assign coef_addr  = base_q + WAW'(feat_q);
	assign vote_idx   = mac_stat.positive ? i_q : j_q;

	// Control to the datapath and tally
	always_comb begin
		mac_ctrl            = '0;
		mac_ctrl.wr_weight  = s_fire && (action == ACT_WEIGHT);
		mac_ctrl.wr_bias    = s_fire && (action == ACT_BIAS);
		mac_ctrl.wr_sample  = sample_in;
		mac_ctrl.issue      = (state_q == ST_MAC);
		mac_ctrl.clear_acc  = start || (state_q == ST_SUM);
		tally_ctrl          = '0;
		tally_ctrl.clear    = start;
		tally_ctrl.vote     = (state_q == ST_SUM);
		tally_ctrl.scan     = (state_q == ST_SCAN);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= FEATURE_COUNT_RST;
			cc_q <= CLASS_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FEATURE_COUNT: fc_q <= cfg_data[FEATURE_COUNT_W-1:0];
				REG_CLASS_COUNT:   cc_q <= cfg_data[CLASS_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: samples, pair loop, feature loop, scan, output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rcv_q      <= '0;
			feat_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			pair_q     <= '0;
			base_q     <= '0;
			m_tvalid_q <= 1'b0;
			class_q    <= '0;
		end else begin
			// Output register: load a finished result, or drop the one taken
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
				class_q    <= CLASS_OUT_W'(best);
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						rcv_q   <= '0;
						feat_q  <= '0;
						i_q     <= '0;
						j_q     <= CW'(1);
						pair_q  <= '0;
						base_q  <= '0;
						state_q <= ST_MAC;
					end else if (sample_in) begin
						rcv_q <= rcv_inc;
					end
				end
				ST_MAC: begin
					if (last_feat) begin
						feat_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						feat_q <= feat_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!mac_stat.busy) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					pair_q <= next_pair;
					base_q <= base_q + WAW'(MAX_FEATURES);
					if (pairs_done || run_out) begin
						i_q     <= '0;
						state_q <= ST_SCAN;
					end else begin
						if (j_more) begin
							j_q <= j_q + 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= CW'(32'(i_q) + 2);
						end
						state_q <= ST_MAC;
					end
				end
				ST_SCAN: begin
					i_q <= i_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ovs_mac #(
		.MAX_FEATURES(MAX_FEATURES),
		.MAX_CLASSES (MAX_CLASSES),
		.MAX_PAIRS   (MAX_PAIRS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mac_ctrl),
		.wr_addr   (address),
		.wr_value  (value),
		.sample_idx(sample_idx),
		.coef_addr (coef_addr),
		.pair      (pair_q),
		.stat      (mac_stat)
	);

	ovs_tally #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (tally_ctrl),
		.vote_idx(vote_idx),
		.scan_idx(i_q),
		.best    (best)
	);

endmodule

FILE: rtl/ovs_mac.sv
// Coefficient, intercept and sample memories with the multiply-accumulate pipeline.
// Depends on ovs_pkg.
module ovs_mac
	import ovs_pkg::*;
#(
	parameter int MAX_FEATURES = DEF_MAX_FEATURES,
	parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
	parameter int MAX_PAIRS    = DEF_MAX_PAIRS,
	localparam int WDEPTH = MAX_PAIRS * MAX_FEATURES,
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1,
	localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
	localparam int BIW    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1,
	localparam int NPAIRS = MAX_CLASSES * (MAX_CLASSES - 1) / 2,
	localparam int PCW    = $clog2(NPAIRS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mac_ctrl_t                 ctrl,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic signed [VALUE_W-1:0] wr_value,
	input  logic [FW-1:0]             sample_idx,
	input  logic [WAW-1:0]            coef_addr,
	input  logic [PCW-1:0]            pair,
	output mac_stat_t                 stat
);

	logic signed [COEF_W-1:0] weight_mem [WDEPTH];
	logic signed [COEF_W-1:0] sample_mem [MAX_FEATURES];
	logic signed [BIAS_W-1:0] bias_mem   [MAX_PAIRS];

	logic signed [COEF_W-1:0] weight_s1;
	logic signed [COEF_W-1:0] sample_s1;
	logic                     vld_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [BIAS_W-1:0] bias_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  sum;

	// Memory writes; out-of-range addresses are dropped
	always_ff @(posedge clk) begin
		if (ctrl.wr_weight && (32'(wr_addr) < WDEPTH)) begin
			weight_mem[WAW'(wr_addr)] <= sat16(wr_value);
		end
		if (ctrl.wr_bias && (32'(wr_addr) < MAX_PAIRS)) begin
			bias_mem[BIW'(wr_addr)] <= wr_value;
		end
		if (ctrl.wr_sample) begin
			sample_mem[sample_idx] <= sat16(wr_value);
		end
	end

	// Registered reads
	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			weight_s1 <= weight_mem[coef_addr];
			sample_s1 <= sample_mem[sample_idx];
		end
		bias_q <= bias_mem[BIW'(pair)];
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= weight_s1 * sample_s1;
	end

	// Pipeline valids and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctrl.issue;
			vld_s2 <= vld_s1;
			if (ctrl.clear_acc) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
			end
		end
	end

	// Intercept add and sign decision
	assign sum           = acc_q + {{(ACC_W-BIAS_W){bias_q[BIAS_W-1]}}, bias_q};
	assign stat.positive = !sum[ACC_W-1] && (sum != '0);
	assign stat.busy     = vld_s1 || vld_s2;

endmodule

FILE: rtl/ovs_tally.sv
// Per-class vote counters and the final scan for the lowest-indexed maximum.
// Depends on ovs_pkg.
module ovs_tally
	import ovs_pkg::*;
#(
	parameter int MAX_CLASSES = DEF_MAX_CLASSES,
	localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tally_ctrl_t   ctrl,
	input  logic [CW-1:0] vote_idx,
	input  logic [CW-1:0] scan_idx,
	output logic [CW-1:0] best
);

	logic [VOTE_W-1:0] votes_q [MAX_CLASSES];
	logic [VOTE_W-1:0] best_votes_q;
	logic [CW-1:0]     best_q;

	// Vote counters wrap at three bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_CLASSES; k++) begin
				votes_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < MAX_CLASSES; k++) begin
				if (ctrl.clear) begin
					votes_q[k] <= '0;
				end else if (ctrl.vote && (vote_idx == CW'(k))) begin
					votes_q[k] <= votes_q[k] + 1'b1;
				end
			end
		end
	end

	// One class per cycle; strict compare keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q       <= '0;
			best_votes_q <= '0;
		end else if (ctrl.clear) begin
			best_q       <= '0;
			best_votes_q <= '0;
		end else if (ctrl.scan && (votes_q[scan_idx] > best_votes_q)) begin
			best_q       <= scan_idx;
			best_votes_q <= votes_q[scan_idx];
		end
	end

	assign best = best_q;

endmodule

FILE: tb/sv/ovs_vote_checker.sv
`timescale 1ns / 1ps
// Checker for the one-vs-one linear SVM classifier: watches every channel, keeps
// its own copy of the stores and registers, predicts each winning class and compares.
// Depends on ovs_pkg.
module ovs_vote_checker
	import ovs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic [S_TUSER_W-1:0]  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           errors_seen,
	output int unsigned           winners_owed
);

	localparam int FEAT_MAX   = DEF_MAX_FEATURES;
	localparam int CLASS_MAX  = DEF_MAX_CLASSES;
	localparam int COEF_DEPTH = DEF_MAX_PAIRS * DEF_MAX_FEATURES;

	// Shadow copies of the block's stores and registers
	logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
	logic signed [BIAS_W-1:0]   icpt_mem [DEF_MAX_PAIRS];
	logic signed [COEF_W-1:0]   feat_mem [FEAT_MAX];
	int unsigned                feats_held;
	logic [FEATURE_COUNT_W-1:0] feat_count_reg;
	logic [CLASS_COUNT_W-1:0]   class_count_reg;

	// Winning classes predicted but not yet seen on the output
	logic [CLASS_OUT_W-1:0] winners_due [$];

	task automatic report_mismatch(input string what);
		$display("[%0t] ovs_vote_checker: %s", $time, what);
		errors_seen++;
	endtask

	// Clip a 32-bit word to 16 bits: in range when the top 17 bits agree
	function automatic logic signed [COEF_W-1:0] clip16(input logic [VALUE_W-1:0] w);
		if (w[VALUE_W-1:COEF_W-1] == '0 || w[VALUE_W-1:COEF_W-1] == '1) begin
			return w[COEF_W-1:0];
		end
		return w[VALUE_W-1] ? 16'sh8000 : 16'sh7fff;
	endfunction

	function automatic int unsigned live_features();
		if (feat_count_reg == 0) begin
			return 1;
		end
		if (feat_count_reg > FEAT_MAX) begin
			return FEAT_MAX;
		end
		return feat_count_reg;
	endfunction

	function automatic int unsigned live_classes();
		if (class_count_reg < 2) begin
			return 2;
		end
		if (class_count_reg > CLASS_MAX) begin
			return CLASS_MAX;
		end
		return class_count_reg;
	endfunction

	// Run every pairwise classifier in pair order, then pick the class with most votes
	function automatic logic [CLASS_OUT_W-1:0] tally_winner();
		logic [VOTE_W-1:0]       votes [CLASS_MAX];
		logic signed [ACC_W-1:0] acc;
		logic [CLASS_OUT_W-1:0]  best;
		int unsigned             nf, nc, pair, top_votes;
		int                      i, j, f;
		nf = live_features();
		nc = live_classes();
		pair = 0;
		foreach (votes[k]) begin
			votes[k] = '0;
		end
		for (i = 0; i < nc; i++) begin
			for (j = i + 1; j < nc; j++) begin
				acc = '0;
				for (f = 0; f < nf; f++) begin
					acc += coef_mem[pair * FEAT_MAX + f] * feat_mem[f];
				end
				acc += icpt_mem[pair];
				// zero is not above zero: the vote goes to the higher class
				if (acc > 0) begin
					votes[i] = votes[i] + 1'b1;
				end else begin
					votes[j] = votes[j] + 1'b1;
				end
				pair++;
			end
		end
		best = '0;
		top_votes = 0;
		for (i = 0; i < nc; i++) begin
			if (votes[i] > top_votes) begin
				top_votes = votes[i];
				best = CLASS_OUT_W'(i);
			end
		end
		return best;
	endfunction

	// Track requests, register writes and results at each rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		logic [ACTION_W-1:0]      act;
		logic [ADDR_W-1:0]        addr;
		logic [VALUE_W-1:0]       word;
		logic [CLASS_OUT_W-1:0]   want;
		logic [CLASS_OUT_W-1:0]   got;
		if (!arst_n) begin
			feats_held = 0;
			feat_count_reg = FEATURE_COUNT_RST;
			class_count_reg = CLASS_COUNT_RST;
			winners_due.delete();
			errors_seen = 0;
			winners_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FEATURE_COUNT: feat_count_reg = cfg_data[FEATURE_COUNT_W-1:0];
					REG_CLASS_COUNT:   class_count_reg = cfg_data[CLASS_COUNT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				act = s_tuser;
				addr = s_tdata[ADDR_W-1:0];
				word = s_tdata[ADDR_W +: VALUE_W];
				case (act)
					ACT_WEIGHT: begin
						if (addr < COEF_DEPTH) begin
							coef_mem[addr] = clip16(word);
						end
					end
					ACT_BIAS: begin
						if (addr < DEF_MAX_PAIRS) begin
							icpt_mem[addr] = word;
						end
					end
					ACT_SAMPLE: begin
						if (feats_held < FEAT_MAX) begin
							feat_mem[feats_held] = clip16(word);
						end
						feats_held++;
						if (feats_held >= live_features()) begin
							feats_held = 0;
							winners_due.push_back(tally_winner());
						end
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[CLASS_OUT_W-1:0];
				if (winners_due.size() == 0) begin
					report_mismatch($sformatf("class %0d with no vector pending", got));
				end else begin
					want = winners_due.pop_front();
					if (got !== want) begin
						report_mismatch($sformatf("class %0d, predicted %0d", got, want));
					end
				end
			end
			winners_owed <= winners_due.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the one-vs-one linear SVM classifier.
// Depends on ovs_pkg, ovo_linear_svm_classifier and ovs_vote_checker.
module tb_top;
	import ovs_pkg::*;

	localparam int WEIGHT_SLOTS = DEF_MAX_PAIRS * DEF_MAX_FEATURES;
	localparam int ADDR_SPAN    = 1 << ADDR_W;
	// Watchdog limit: even if every request closed a full-size run,
	// the run would stay well below this
	localparam int RUN_LIMIT    = 10_000_000;
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;   // address[10:0], value[42:11], zero pad
	logic [S_TUSER_W-1:0]  s_tuser   = '0;   // action[1:0]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;          // class_index[2:0], zero pad
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int unsigned errors_seen;
	int unsigned winners_owed;

	// Stimulus bookkeeping: which store entries hold data, current sizes
	bit          weight_set [WEIGHT_SLOTS];
	bit          bias_set [DEF_MAX_PAIRS];
	int unsigned feat_now, class_now, pairs_now;
	int unsigned items_sent    = 0;
	int unsigned hold_request  = 0;
	int unsigned cycle_no      = 0;
	bit          gaps_on       = 1'b1;

	ovo_linear_svm_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ovs_vote_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors_seen  (errors_seen),
		.winners_owed (winners_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no == RUN_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Result receiver: random stalls, plus one long hold-off on request
	initial begin : drain
		int unsigned stall;
		forever begin
			stall = gaps_on ? $urandom_range(0, 5) : 0;
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic int unsigned live_count(input int unsigned raw, input int unsigned lo,
			input int unsigned hi);
		return (raw < lo) ? lo : ((raw > hi) ? hi : raw);
	endfunction

	// Mostly moderate values so votes split, with saturating and full-range words mixed in
	function automatic logic [VALUE_W-1:0] draw_word();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			return $urandom();
		end
		if (pick == 1) begin
			case ($urandom_range(0, 5))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0000_7fff;
				3: return 32'h0000_8000;
				4: return 32'hffff_8000;
				default: return 32'hffff_7fff;
			endcase
		end
		return 32'($urandom_range(0, 2000)) - 32'd1000;
	endfunction

	function automatic logic [VALUE_W-1:0] draw_intercept();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			return $urandom();
		end
		if (pick == 1) begin
			return '0;
		end
		return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
	endfunction

	task automatic push_request(input logic [ACTION_W-1:0] act, input int unsigned addr,
			input logic [VALUE_W-1:0] word);
		int unsigned pause;
		pause = gaps_on ? $urandom_range(0, 5) : 0;
		if (pause > 0) begin
			s_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		s_tuser <= act;
		s_tdata <= {{(S_TDATA_W - ADDR_W - VALUE_W){1'b0}}, word, addr[ADDR_W-1:0]};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (act == ACT_WEIGHT && addr < WEIGHT_SLOTS) begin
			weight_set[addr] = 1'b1;
		end
		if (act == ACT_BIAS && addr < DEF_MAX_PAIRS) begin
			bias_set[addr] = 1'b1;
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Give every entry the coming classifications read a value
	task automatic fill_stores();
		int unsigned p, f;
		for (p = 0; p < pairs_now; p++) begin
			if (!bias_set[p]) begin
				push_request(ACT_BIAS, p, draw_intercept());
			end
			for (f = 0; f < feat_now; f++) begin
				if (!weight_set[p * DEF_MAX_FEATURES + f]) begin
					push_request(ACT_WEIGHT, p * DEF_MAX_FEATURES + f, draw_word());
				end
			end
		end
	endtask

	// Drain the block, then write both registers (and sometimes an unused index)
	task automatic settle_and_configure(input logic [CFG_DATA_W-1:0] fc_raw,
			input logic [CFG_DATA_W-1:0] cc_raw);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (winners_owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		write_register(REG_FEATURE_COUNT, fc_raw);
		write_register(REG_CLASS_COUNT, cc_raw);
		if ($urandom_range(0, 2) == 0) begin
			write_register(CFG_IDX_W'($urandom_range(REG_CLASS_COUNT + 1, 15)),
				CFG_DATA_W'($urandom()));
		end
		cfg_valid <= 1'b0;
		feat_now = live_count(fc_raw[FEATURE_COUNT_W-1:0], 1, DEF_MAX_FEATURES);
		class_now = live_count(cc_raw[CLASS_COUNT_W-1:0], 2, DEF_MAX_CLASSES);
		pairs_now = class_now * (class_now - 1) / 2;
		fill_stores();
	endtask

	// One random request: sample, coefficient, intercept or the unused action
	task automatic random_request();
		int unsigned pick, sub, addr;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			push_request(ACT_SAMPLE, $urandom_range(0, ADDR_SPAN - 1), draw_word());
		end else if (pick < 80) begin
			sub = $urandom_range(0, 9);
			if (sub < 7) begin
				addr = $urandom_range(0, pairs_now - 1) * DEF_MAX_FEATURES +
					$urandom_range(0, feat_now - 1);
			end else if (sub < 9) begin
				addr = $urandom_range(0, WEIGHT_SLOTS - 1);
			end else begin
				addr = $urandom_range(WEIGHT_SLOTS, ADDR_SPAN - 1);
			end
			push_request(ACT_WEIGHT, addr, draw_word());
		end else if (pick < 92) begin
			sub = $urandom_range(0, 9);
			if (sub < 8) begin
				addr = $urandom_range(0, pairs_now - 1);
			end else if (sub < 9) begin
				addr = $urandom_range(0, DEF_MAX_PAIRS - 1);
			end else begin
				addr = $urandom_range(DEF_MAX_PAIRS, ADDR_SPAN - 1);
			end
			push_request(ACT_BIAS, addr, draw_intercept());
		end else begin
			push_request(ACT_NONE, $urandom(), $urandom());
		end
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] fc_raw, cc_raw;
		int unsigned           phase_no, len, i;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest sizes: one feature, one classifier; saturation and sign cases
		settle_and_configure(8'd1, 8'd2);
		push_request(ACT_WEIGHT, 0, 32'h7fff_ffff);
		push_request(ACT_BIAS, 0, 32'h0);
		push_request(ACT_SAMPLE, 0, 32'h0);           // sum exactly zero
		push_request(ACT_SAMPLE, 0, 32'h8000_0000);
		push_request(ACT_SAMPLE, ADDR_SPAN - 1, 32'h1);
		push_request(ACT_WEIGHT, 0, 32'h8000_0000);
		push_request(ACT_SAMPLE, 0, 32'hffff_8000);
		push_request(ACT_BIAS, 0, 32'h8000_0000);     // sum below -2^31
		push_request(ACT_SAMPLE, 0, 32'h7fff_ffff);
		push_request(ACT_BIAS, 0, 32'h7fff_ffff);     // sum above 2^31
		push_request(ACT_SAMPLE, 0, 32'hffff_8000);
		// ignored writes: addresses past the stores, unused action
		push_request(ACT_WEIGHT, WEIGHT_SLOTS, 32'd5);
		push_request(ACT_WEIGHT, ADDR_SPAN - 1, 32'h7fff_ffff);
		push_request(ACT_BIAS, DEF_MAX_PAIRS, 32'h7fff_ffff);
		push_request(ACT_BIAS, ADDR_SPAN - 1, 32'h8000_0000);
		push_request(ACT_NONE, ADDR_SPAN - 1, 32'hffff_ffff);
		push_request(ACT_SAMPLE, 0, 32'h1);
		push_request(ACT_WEIGHT, 0, 32'h0000_8000);
		push_request(ACT_SAMPLE, 0, 32'hffff_7fff);

		// Register values below range clamp up
		settle_and_configure(8'd0, 8'd1);
		push_request(ACT_SAMPLE, 0, draw_word());
		push_request(ACT_SAMPLE, 0, draw_word());

		// All data bits set: 64 features, class count zero clamps to two
		settle_and_configure(8'hff, 8'd0);
		for (i = 0; i < DEF_MAX_FEATURES + 5; i++) begin
			push_request(ACT_SAMPLE, 0, draw_word());
		end
		// Shrink the vector mid-way: the held samples complete it at once
		settle_and_configure(8'd3, 8'd15);
		for (i = 0; i < 10; i++) begin
			push_request(ACT_SAMPLE, 0, draw_word());
		end
		settle_and_configure(8'd64, 8'd2);
		for (i = 0; i < 70; i++) begin
			push_request(ACT_SAMPLE, 0, draw_word());
		end
		settle_and_configure(8'd2, 8'd8);
		for (i = 0; i < 12; i++) begin
			push_request(ACT_SAMPLE, 0, draw_word());
		end

		// Random phases, mostly small vectors; the stall phase always runs
		phase_no = 0;
		while (items_sent < 550 || phase_no < 3) begin
			if (phase_no == 2) begin
				// Receiver holds off while samples keep coming; the block must stall
				settle_and_configure(8'd1, 8'd2);
				gaps_on = 1'b0;
				hold_request = 600;
				for (i = 0; i < 30; i++) begin
					push_request(ACT_SAMPLE, 0, draw_word());
				end
			end else begin
				len = $urandom_range(0, 9);
				if (len < 6) begin
					fc_raw = CFG_DATA_W'($urandom_range(1, 4));
				end else if (len < 8) begin
					fc_raw = CFG_DATA_W'($urandom_range(5, 12));
				end else begin
					fc_raw = CFG_DATA_W'($urandom_range(0, 255));
				end
				if (live_count(fc_raw[FEATURE_COUNT_W-1:0], 1, DEF_MAX_FEATURES) > 12) begin
					cc_raw = CFG_DATA_W'($urandom_range(0, 3));
				end else begin
					cc_raw = CFG_DATA_W'($urandom_range(0, 255));
				end
				settle_and_configure(fc_raw, cc_raw);
				gaps_on = ($urandom_range(0, 3) != 0);
				len = $urandom_range(20, 60);
				repeat (len) random_request();
			end
			phase_no++;
		end

		gaps_on = 1'b1;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (winners_owed != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (errors_seen == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

FILE: ovo_linear_svm_classifier.f
rtl/ovs_pkg.sv
rtl/ovs_mac.sv
rtl/ovs_tally.sv
rtl/ovo_linear_svm_classifier.sv
tb/sv/ovs_vote_checker.sv
tb/sv/tb_top.sv
